FILE: design/spq_pkg.sv
// package for the sorted priority queue
// shared widths, operation and status codes, the cell command type
// no dependencies
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 5;
  localparam int DEF_CAPACITY = 16;

  typedef logic [OP_W-1:0]            op_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [OCC_W-1:0]           occ_t;
  typedef logic signed [DATA_W-1:0]   data_t;

  localparam op_t OP_INSERT = op_t'(0);
  localparam op_t OP_PEEK   = op_t'(1);
  localparam op_t OP_DELETE = op_t'(2);

  localparam status_t ST_OK    = status_t'(0);
  localparam status_t ST_EMPTY = status_t'(1);
  localparam status_t ST_FULL  = status_t'(2);

  // broadcast to every cell in the chain
  typedef struct packed {
    logic  ins;
    logic  del;
    data_t value;
    data_t prio;
  } spq_cmd_t;

  // one result beat
  typedef struct packed {
    data_t   result_value;
    status_t status;
    occ_t    occupancy;
  } spq_res_t;

endpackage

FILE: design/spq_if.sv
// valid/ready channel interfaces for operation and result beats
// depends on spq_pkg
interface spq_in_if;
  logic                 valid;
  logic                 ready;
  spq_pkg::op_t         operation;
  spq_pkg::data_t       value;
  spq_pkg::data_t       priority_req;

  modport source (output valid, output operation, output value, output priority_req,
                  input ready);
  modport sink   (input valid, input operation, input value, input priority_req,
                  output ready);
endinterface

interface spq_out_if;
  logic                 valid;
  logic                 ready;
  spq_pkg::data_t       result_value;
  spq_pkg::status_t     status;
  spq_pkg::occ_t        occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_value, input status, input occupancy,
                  output ready);
endinterface

FILE: design/spq_cell.sv
// one slot of the sorted chain: holds value and priority, shifts with neighbors
// depends on spq_pkg
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t cmd,
  input  logic              occupied,
  input  logic              left_gt,
  input  spq_pkg::data_t    left_val,
  input  spq_pkg::data_t    left_pri,
  input  spq_pkg::data_t    right_val,
  input  spq_pkg::data_t    right_pri,
  output logic              gt,
  output spq_pkg::data_t    val,
  output spq_pkg::data_t    pri
);
  import spq_pkg::*;

  data_t val_r, val_nxt;
  data_t pri_r, pri_nxt;

  // stays put on insert while it outranks the new entry
  assign gt  = occupied && (pri_r > cmd.prio);
  assign val = val_r;
  assign pri = pri_r;

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (cmd.ins) begin
      if (!gt) begin
        if (left_gt) begin
          val_nxt = cmd.value;
          pri_nxt = cmd.prio;
        end else begin
          val_nxt = left_val;
          pri_nxt = left_pri;
        end
      end
    end else if (cmd.del) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

endmodule

FILE: design/sorted_priority_queue.sv
// top level of the sorted priority queue: a chain of spq_cell slots
// depends on spq_pkg, spq_if, spq_cell
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    operation, value, priority_req
//   out_ch   out  valid / ready    result_value, status, occupancy
//
// every operation compares the new entry against all slots in parallel, and each
// slot keeps its entry, takes the new entry, or loads its left or right neighbor
// one result beat per operation beat, held in an output register
// a new beat is taken while the result register is empty or being drained
// rst_n (synchronous) clears the fill count and the result valid, slot data
// stays as it is and is never read above the fill count
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  spq_res_t         res_r, res_nxt;
  spq_cmd_t         cmd;
  logic             in_fire;
  logic             is_empty, is_full;

  data_t               cell_val [CAPACITY];
  data_t               cell_pri [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == CNT_W'(CAPACITY));

  // decode the beat: cell command, next fill count, result
  always_comb begin
    cmd.ins              = 1'b0;
    cmd.del              = 1'b0;
    cmd.value            = in_ch.value;
    cmd.prio             = in_ch.priority_req;
    count_nxt            = count_r;
    res_nxt.result_value = '0;
    res_nxt.status       = ST_OK;
    case (in_ch.operation)
      OP_INSERT: begin
        if (is_full) begin
          res_nxt.status = ST_FULL;
        end else begin
          cmd.ins   = in_fire;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.result_value = cell_val[0];
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          cmd.del              = in_fire;
          res_nxt.result_value = cell_val[0];
          count_nxt            = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
    res_nxt.occupancy = OCC_W'(count_nxt);
  end

  // the chain, head at slot 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic  lgt;
    data_t lval, lpri, rval, rpri;

    if (g == 0) begin : g_head
      // the head takes the new entry unless it outranks it
      assign lgt  = 1'b1;
      assign lval = cmd.value;
      assign lpri = cmd.prio;
    end else begin : g_mid
      assign lgt  = cell_gt[g-1];
      assign lval = cell_val[g-1];
      assign lpri = cell_pri[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rval = cell_val[g];
      assign rpri = cell_pri[g];
    end else begin : g_body
      assign rval = cell_val[g+1];
      assign rpri = cell_pri[g+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (count_r > CNT_W'(g)),
      .left_gt   (lgt),
      .left_val  (lval),
      .left_pri  (lpri),
      .right_val (rval),
      .right_pri (rpri),
      .gt        (cell_gt[g]),
      .val       (cell_val[g]),
      .pri       (cell_pri[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_r.result_value;
  assign out_ch.status       = res_r.status;
  assign out_ch.occupancy    = res_r.occupancy;

  // fill count never passes the capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // a taken insert into a queue with room grows it by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation == OP_INSERT && !is_full)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  // a taken delete returns the old head
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.operation == OP_DELETE && !is_empty)
      |=> (res_r.result_value == $past(cell_val[0]) && res_r.status == ST_OK))
    else $error("delete returned a value other than the head");

  // a dropped insert is only reported for a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == ST_FULL) |-> is_full)
    else $error("full status with room left");

  // occupied slots stay in descending priority order
  for (genvar a = 0; a < CAPACITY - 1; a++) begin : g_order_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      (count_r > CNT_W'(a + 1)) |-> (cell_pri[a] >= cell_pri[a+1]))
      else $error("chain out of priority order");
  end

endmodule

FILE: verif/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// self-checking bench for sorted_priority_queue: directed table, then random operations
// depends on spq_pkg and spq_if from the design folder and on the sorted_priority_queue rtl
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RAND_ITEMS   = 1650;
  localparam int QUIET_ITEMS  = 200;   // tail of the run with no idling on either side
  localparam int STALL_LIMIT  = 1000;  // cycles with no beat on either channel
  localparam int DRAIN_LIMIT  = 500;
  localparam int TAIL_CYCLES  = 8;

  localparam op_t   OP_UNUSED = op_t'(3);
  localparam data_t DATA_MAX  = data_t'(32'h7fff_ffff);
  localparam data_t DATA_MIN  = data_t'(32'h8000_0000);

  // operation mix of one random segment
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    op_t      op;
    data_t    value;
    data_t    prio;
    bit       typed;
    spq_res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  op_bus ();
  spq_out_if res_bus ();

  sorted_priority_queue #(.CAPACITY(CAPACITY)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_bus),
    .out_ch (res_bus)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the queue contents, head at slot 0, descending priority
  data_t mirror_value [CAPACITY];
  data_t mirror_prio  [CAPACITY];
  int    mirror_fill;

  spq_res_t  pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        quiet_cycles;

  // typed expectation that travels with the beat currently on the op channel
  logic     row_typed;
  spq_res_t row_want;

  bit tx_idle;
  bit rx_idle;

  // applies one operation to the shadow queue and returns the result beat it causes
  function automatic spq_res_t apply_queue_op(op_t op, data_t val, data_t pri);
    spq_res_t r;
    int       pos;
    r.result_value = '0;
    r.status       = ST_OK;
    case (op)
      OP_INSERT: begin
        if (mirror_fill >= CAPACITY) begin
          // full: the entry is dropped
          r.status = ST_FULL;
        end else begin
          // new entry goes ahead of every entry with priority <= its own
          pos = 0;
          while (pos < mirror_fill && mirror_prio[pos] > pri) pos++;
          for (int i = mirror_fill; i > pos; i--) begin
            mirror_value[i] = mirror_value[i-1];
            mirror_prio[i]  = mirror_prio[i-1];
          end
          mirror_value[pos] = val;
          mirror_prio[pos]  = pri;
          mirror_fill++;
        end
      end
      OP_PEEK: begin
        if (mirror_fill == 0) r.status = ST_EMPTY;
        else r.result_value = mirror_value[0];
      end
      OP_DELETE: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_value = mirror_value[0];
          for (int i = 0; i + 1 < mirror_fill; i++) begin
            mirror_value[i] = mirror_value[i+1];
            mirror_prio[i]  = mirror_prio[i+1];
          end
          mirror_fill--;
        end
      end
      default: ;  // unused code changes nothing
    endcase
    r.occupancy = occ_t'(mirror_fill);
    return r;
  endfunction

  task automatic add_row(op_t op, data_t val, data_t pri, bit typed,
                         data_t w_val, status_t w_st, occ_t w_occ);
    stim_row_t row;
    row.op                = op;
    row.value             = val;
    row.prio              = pri;
    row.typed             = typed;
    row.want.result_value = w_val;
    row.want.status       = w_st;
    row.want.occupancy    = w_occ;
    directed_rows.push_back(row);
  endtask

  // drives one operation beat from a falling edge and returns at the falling edge
  // after it was taken; may leave a random gap behind it
  task automatic send_beat(op_t op, data_t val, data_t pri, bit typed, spq_res_t want);
    op_bus.valid        <= 1'b1;
    op_bus.operation    <= op;
    op_bus.value        <= val;
    op_bus.priority_req <= pri;
    row_typed           <= typed;
    row_want            <= want;
    @(posedge clk);
    while (!op_bus.ready) @(posedge clk);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      op_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // scoreboard: results are checked first so an unexpected beat never pairs
  // with an operation taken at the same edge
  always @(posedge clk) begin : scoreboard
    spq_res_t want;
    spq_res_t got;
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: value %0d status %0d occupancy %0d",
                 res_bus.result_value, res_bus.status, res_bus.occupancy);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_bus.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   res_bus.result_value);
            mismatch_count++;
          end
          if (res_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_bus.status);
            mismatch_count++;
          end
          if (res_bus.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, res_bus.occupancy);
            mismatch_count++;
          end
        end
      end
      if (op_bus.valid && op_bus.ready) begin
        // shadow always advances; typed rows replace the computed beat
        got = apply_queue_op(op_bus.operation, op_bus.value, op_bus.priority_req);
        pending_results.push_back(row_typed ? row_want : got);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (rx_idle && rst_n && $urandom_range(0, 7) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int       seg_left;
    int       roll;
    int       ins_pct;
    int       drain_wait;
    bit       rx_pick;
    mix_t     mix;
    op_t      op;
    data_t    val;
    data_t    pri;
    spq_res_t blank;

    // every input known from time zero
    rst_n               = 1'b0;
    op_bus.valid        = 1'b0;
    op_bus.operation    = OP_INSERT;
    op_bus.value        = '0;
    op_bus.priority_req = '0;
    res_bus.ready       = 1'b1;
    row_typed           = 1'b0;
    row_want            = '0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    mismatch_count      = 0;
    quiet_cycles        = 0;
    mirror_fill         = 0;
    blank               = '0;
    seg_left            = 0;
    mix                 = MIX_BALANCED;
    rx_pick             = 1'b1;

    // directed part: empty cases, unused code, extremes, tie order, full queue
    add_row(OP_PEEK,   DATA_MAX, DATA_MAX, 1'b1, 0, ST_EMPTY, 0);
    add_row(OP_DELETE, DATA_MIN, DATA_MIN, 1'b1, 0, ST_EMPTY, 0);
    add_row(OP_UNUSED, -1,       -1,       1'b1, 0, ST_OK,    0);
    add_row(OP_INSERT, DATA_MAX, DATA_MAX, 1'b1, 0, ST_OK,    1);
    add_row(OP_INSERT, DATA_MIN, DATA_MIN, 1'b1, 0, ST_OK,    2);
    // equal top priority: newest entry wins the head
    add_row(OP_INSERT, -1,       DATA_MAX, 1'b1, 0, ST_OK,    3);
    add_row(OP_PEEK,   0,        0,        1'b1, -1, ST_OK,   3);
    add_row(OP_DELETE, 0,        0,        1'b1, -1, ST_OK,   2);
    add_row(OP_DELETE, 0,        0,        1'b1, DATA_MAX, ST_OK, 1);
    add_row(OP_UNUSED, 12345,    -7,       1'b1, 0, ST_OK,    1);
    add_row(OP_INSERT, 0,        0,        1'b0, 0, ST_OK,    0);
    // fill up to capacity with mixed, partly tied priorities
    for (int i = 0; i < CAPACITY - 2; i++)
      add_row(OP_INSERT, data_t'(32'h5a5a_0000 + i), data_t'((i * 5) % 7) - 3,
              1'b0, 0, ST_OK, 0);
    // insert into a full queue is dropped
    add_row(OP_INSERT, data_t'(32'h1234_5678), DATA_MAX, 1'b1, 0, ST_FULL, occ_t'(CAPACITY));
    add_row(OP_PEEK,   0,        0,        1'b0, 0, ST_OK,    0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
                directed_rows[i].typed, directed_rows[i].want);

    // random part in segments that push the fill level up, down or around
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        mix      = mix_t'($urandom_range(0, 2));
        tx_idle  = $urandom_range(0, 2) != 0;
        rx_pick  = $urandom_range(0, 2) != 0;
      end
      seg_left--;
      if (n >= RAND_ITEMS - QUIET_ITEMS) begin
        tx_idle = 1'b0;
        rx_pick = 1'b0;
      end
      rx_idle <= rx_pick;

      // hold off until every pending result has drained
      if (n == RAND_ITEMS / 3 || n == 2 * RAND_ITEMS / 3) begin
        op_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end

      case (mix)
        MIX_FILL:  ins_pct = 70;
        MIX_DRAIN: ins_pct = 15;
        default:   ins_pct = 45;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)           op = OP_INSERT;
      else if (roll < ins_pct + 12) op = OP_PEEK;
      else if (roll < 96)           op = OP_DELETE;
      else                          op = OP_UNUSED;

      // small priorities give plenty of ties
      roll = $urandom_range(0, 9);
      if (roll < 4)
        pri = data_t'($urandom_range(0, 7)) - 4;
      else if (roll < 6)
        case ($urandom_range(0, 3))
          0:       pri = DATA_MAX;
          1:       pri = DATA_MIN;
          2:       pri = 0;
          default: pri = -1;
        endcase
      else
        pri = data_t'($urandom);

      if ($urandom_range(0, 9) < 8) val = data_t'($urandom);
      else val = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;

      send_beat(op, val, pri, 1'b0, blank);
    end

    // all beats sent: drain, then a short tail for stray results
    op_bus.valid <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
